FILE: hw/rtl/fmu_pkg.sv
package fmu_pkg;

	// Fixed-point widths
	localparam int DIST_W  = 32;
	localparam int EXP_W   = 16;
	localparam int MEMB_W  = 17;
	localparam int IDX_W   = 3;
	localparam int LOG_W   = 21;
	localparam int FRAC_W  = 16;
	localparam int TERM_W  = 57;
	localparam int SUM_W   = 62;
	localparam int NUM_W   = 41;
	localparam int EXP_RST = 4096;

	// Datapath operations, one per cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_STORE,
		OP_CLR_C,
		OP_LOG_LOAD,
		OP_LOG_NORM,
		OP_LOG_MUL,
		OP_LOG_SQ,
		OP_LOG_WR,
		OP_ROW_INIT,
		OP_EXP_DIFF,
		OP_EXP_T,
		OP_EXP_MUL,
		OP_EXP_ACC,
		OP_EXP_SUM,
		OP_DIV_MEMB,
		OP_DIV_SHARE,
		OP_DIV_STEP,
		OP_MEMB_WR,
		OP_SHARE_FILL,
		OP_OUT_LOAD,
		OP_OUT_NEXT,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic np_zero;
		logic x_top;
		logic k_last;
		logic c_last;
		logic i_last;
		logic j_zero;
		logic div_done;
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START,
		S_LOG_LOAD,
		S_LOG_NORM,
		S_LOG_MUL,
		S_LOG_SQ,
		S_LOG_WR,
		S_PAIR_INIT,
		S_ROW_INIT,
		S_EXP_DIFF,
		S_EXP_T,
		S_EXP_MUL,
		S_EXP_ACC,
		S_EXP_SUM,
		S_DIV_INIT,
		S_DIV,
		S_DIV_WR,
		S_SHARE_DIV,
		S_SHARE_INIT,
		S_SHARE_FILL,
		S_OUT_INIT,
		S_OUT_LOAD,
		S_OUT
	} state_t;

	// Successive square roots of two, Q2.30
	typedef logic [16:0][31:0] root_tbl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bits;
		v    = v_in;
		res  = '0;
		bits = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (v >= res + bits) begin
				v   = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	function automatic root_tbl_t build_roots();
		root_tbl_t r;
		logic [63:0] sq;
		r[0] = 32'h8000_0000;
		for (int k = 1; k <= 16; k++) begin
			sq   = isqrt64({32'd0, r[k-1]} << 30);
			r[k] = sq[31:0];
		end
		return r;
	endfunction

	localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

FILE: hw/rtl/fmu_datapath.sv
module fmu_datapath #(
	parameter int MAX_CLUSTERS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fmu_pkg::cmd_t                   cmd,
	output fmu_pkg::status_t                stat,
	input  logic                            cfg_wr_en,
	input  logic [fmu_pkg::EXP_W-1:0]       cfg_wr_data,
	input  logic signed [fmu_pkg::DIST_W-1:0] distance,
	output logic [fmu_pkg::IDX_W-1:0]       cluster_index,
	output logic [fmu_pkg::MEMB_W-1:0]      membership,
	output logic [fmu_pkg::MEMB_W-1:0]      previous_membership,
	output logic [fmu_pkg::IDX_W-1:0]       best_cluster,
	output logic                            last_result
);
	import fmu_pkg::*;

	localparam int CW   = $clog2(MAX_CLUSTERS);
	localparam int CNTW = $clog2(MAX_CLUSTERS + 1);

	// Stores
	logic signed [DIST_W-1:0] dist_q  [MAX_CLUSTERS];
	logic [LOG_W-1:0]         log_q   [MAX_CLUSTERS];
	logic [MEMB_W-1:0]        newm_q  [MAX_CLUSTERS];
	logic [MEMB_W-1:0]        mstore_q[MAX_CLUSTERS];

	logic [CNTW-1:0]   cnt_q, np_q;
	logic [CW-1:0]     c_q, i_q, best_q;
	logic [MEMB_W-1:0] best_val_q;
	logic [EXP_W-1:0]  exp_q;

	// Log and exp working registers
	logic [31:0]        x_q;
	logic [4:0]         p_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [3:0]         k_q, j_q;
	logic [63:0]        prod_q;
	logic signed [37:0] eprod_q;
	logic [LOG_W-1:0]   logc_q;
	logic [31:0]        mant_q;
	logic [21:0]        u_q;
	logic [SUM_W-1:0]   sum_q;

	// Divider
	logic [NUM_W-1:0]   num_q;
	logic [SUM_W-1:0]   den_q;
	logic [SUM_W-1:0]   rem_q;
	logic [MEMB_W-1:0]  quo_q;
	logic [5:0]         step_q;

	// Output register
	logic [IDX_W-1:0]   oidx_q, obest_q;
	logic [MEMB_W-1:0]  omemb_q, oprev_q;
	logic               olast_q;

	logic [32:0]        sq;
	logic signed [21:0] diff;
	logic signed [25:0] t_raw, t_cl;
	logic [5:0]         sh;
	logic [TERM_W-1:0]  term;
	logic [SUM_W:0]     rem2;
	logic [4:0]         root_idx;
	logic [MEMB_W-1:0]  wr_val;
	logic               best_upd;

	// Status towards the controller
	always_comb begin
		stat.np_zero  = (np_q == '0);
		stat.x_top    = x_q[31];
		stat.k_last   = (k_q == 4'd15);
		stat.c_last   = (CNTW'(c_q) == cnt_q - CNTW'(1));
		stat.i_last   = (CNTW'(i_q) == cnt_q - CNTW'(1));
		stat.j_zero   = (j_q == 4'd0);
		stat.div_done = (step_q == 6'(NUM_W - 1));
	end

	// Arithmetic of the current step
	always_comb begin
		sq       = prod_q[63:31];
		diff     = signed'({1'b0, logc_q}) - signed'({1'b0, log_q[i_q]});
		t_raw    = 26'(eprod_q >>> 12);
		if (t_raw < -26'sd2097152) begin
			t_cl = -26'sd2097152;
		end else if (t_raw > 26'sd2097151) begin
			t_cl = 26'sd2097151;
		end else begin
			t_cl = t_raw;
		end
		sh       = u_q[21:16];
		if (sh >= 6'd38) begin
			term = TERM_W'(mant_q) << (sh - 6'd38);
		end else begin
			term = TERM_W'(mant_q >> (6'd38 - sh));
		end
		rem2     = {rem_q, num_q[NUM_W-1]};
		root_idx = 5'd16 - 5'(j_q);
		if (cmd.op == OP_SHARE_FILL) begin
			wr_val = (dist_q[c_q] <= 0) ? quo_q : '0;
		end else begin
			wr_val = quo_q;
		end
		best_upd = (c_q == '0) || (wr_val > best_val_q);
	end

	// Configuration register, control counters and stored memberships
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= EXP_W'(EXP_RST);
			cnt_q  <= '0;
			np_q   <= '0;
			for (int e = 0; e < MAX_CLUSTERS; e++) begin
				mstore_q[e] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				exp_q <= cfg_wr_data;
			end
			case (cmd.op)
				OP_STORE: begin
					if (cnt_q < CNTW'(MAX_CLUSTERS)) begin
						cnt_q <= cnt_q + CNTW'(1);
						if (distance <= 0) begin
							np_q <= np_q + CNTW'(1);
						end
					end
				end
				OP_OUT_LOAD: mstore_q[c_q] <= newm_q[c_q];
				OP_FINISH: begin
					cnt_q <= '0;
					np_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_STORE: begin
				if (cnt_q < CNTW'(MAX_CLUSTERS)) begin
					dist_q[cnt_q[CW-1:0]] <= distance;
				end
			end
			OP_CLR_C: c_q <= '0;
			OP_LOG_LOAD: begin
				x_q    <= dist_q[c_q];
				p_q    <= 5'd31;
				frac_q <= '0;
				k_q    <= '0;
			end
			OP_LOG_NORM: begin
				if (!x_q[31]) begin
					x_q <= x_q << 1;
					p_q <= p_q - 5'd1;
				end
			end
			OP_LOG_MUL: prod_q <= x_q * x_q;
			OP_LOG_SQ: begin
				frac_q <= {frac_q[FRAC_W-2:0], sq[32]};
				x_q    <= sq[32] ? sq[32:1] : sq[31:0];
				k_q    <= k_q + 4'd1;
			end
			OP_LOG_WR: begin
				log_q[c_q] <= {p_q, frac_q};
				c_q        <= c_q + CW'(1);
			end
			OP_ROW_INIT: begin
				i_q    <= '0;
				sum_q  <= '0;
				logc_q <= log_q[c_q];
			end
			OP_EXP_DIFF: eprod_q <= diff * signed'({1'b0, exp_q});
			OP_EXP_T: begin
				u_q    <= {~t_cl[21], t_cl[20:0]};
				mant_q <= 32'h4000_0000;
				j_q    <= 4'd15;
			end
			OP_EXP_MUL: prod_q <= mant_q * ROOT_TBL[root_idx];
			OP_EXP_ACC: begin
				if (u_q[j_q]) begin
					mant_q <= prod_q[61:30];
				end
				j_q <= j_q - 4'd1;
			end
			OP_EXP_SUM: begin
				sum_q <= sum_q + SUM_W'(term);
				i_q   <= i_q + CW'(1);
			end
			OP_DIV_MEMB: begin
				num_q  <= NUM_W'(1) << (NUM_W - 1);
				den_q  <= sum_q;
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= '0;
			end
			OP_DIV_SHARE: begin
				num_q  <= NUM_W'(65536);
				den_q  <= SUM_W'(np_q);
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= '0;
			end
			OP_DIV_STEP: begin
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= SUM_W'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[MEMB_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2[SUM_W-1:0];
					quo_q <= {quo_q[MEMB_W-2:0], 1'b0};
				end
				num_q  <= num_q << 1;
				step_q <= step_q + 6'd1;
			end
			OP_MEMB_WR, OP_SHARE_FILL: begin
				newm_q[c_q] <= wr_val;
				if (best_upd) begin
					best_q     <= c_q;
					best_val_q <= wr_val;
				end
				c_q <= c_q + CW'(1);
			end
			OP_OUT_LOAD: begin
				oidx_q  <= IDX_W'(c_q);
				omemb_q <= newm_q[c_q];
				oprev_q <= mstore_q[c_q];
				obest_q <= IDX_W'(best_q);
				olast_q <= stat.c_last;
			end
			OP_OUT_NEXT: c_q <= c_q + CW'(1);
			default: ;
		endcase
	end

	assign cluster_index       = oidx_q;
	assign membership          = omemb_q;
	assign previous_membership = oprev_q;
	assign best_cluster        = obest_q;
	assign last_result         = olast_q;

endmodule

FILE: hw/rtl/fmu_ctrl.sv
module fmu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  fmu_pkg::status_t stat,
	output fmu_pkg::cmd_t    cmd
);
	import fmu_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the datapath
	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_STORE;
					if (in_last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.op = OP_CLR_C;
				if (stat.np_zero) begin
					state_d = S_LOG_LOAD;
				end else begin
					state_d = S_SHARE_DIV;
				end
			end
			S_LOG_LOAD: begin
				cmd.op  = OP_LOG_LOAD;
				state_d = S_LOG_NORM;
			end
			S_LOG_NORM: begin
				cmd.op = OP_LOG_NORM;
				if (stat.x_top) begin
					state_d = S_LOG_MUL;
				end
			end
			S_LOG_MUL: begin
				cmd.op  = OP_LOG_MUL;
				state_d = S_LOG_SQ;
			end
			S_LOG_SQ: begin
				cmd.op  = OP_LOG_SQ;
				state_d = stat.k_last ? S_LOG_WR : S_LOG_MUL;
			end
			S_LOG_WR: begin
				cmd.op  = OP_LOG_WR;
				state_d = stat.c_last ? S_PAIR_INIT : S_LOG_LOAD;
			end
			S_PAIR_INIT: begin
				cmd.op  = OP_CLR_C;
				state_d = S_ROW_INIT;
			end
			S_ROW_INIT: begin
				cmd.op  = OP_ROW_INIT;
				state_d = S_EXP_DIFF;
			end
			S_EXP_DIFF: begin
				cmd.op  = OP_EXP_DIFF;
				state_d = S_EXP_T;
			end
			S_EXP_T: begin
				cmd.op  = OP_EXP_T;
				state_d = S_EXP_MUL;
			end
			S_EXP_MUL: begin
				cmd.op  = OP_EXP_MUL;
				state_d = S_EXP_ACC;
			end
			S_EXP_ACC: begin
				cmd.op  = OP_EXP_ACC;
				state_d = stat.j_zero ? S_EXP_SUM : S_EXP_MUL;
			end
			S_EXP_SUM: begin
				cmd.op  = OP_EXP_SUM;
				state_d = stat.i_last ? S_DIV_INIT : S_EXP_DIFF;
			end
			S_DIV_INIT: begin
				cmd.op  = OP_DIV_MEMB;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = S_DIV_WR;
				end
			end
			S_DIV_WR: begin
				cmd.op  = OP_MEMB_WR;
				state_d = stat.c_last ? S_OUT_INIT : S_ROW_INIT;
			end
			S_SHARE_DIV: begin
				cmd.op  = OP_DIV_SHARE;
				state_d = S_SHARE_INIT;
			end
			S_SHARE_INIT: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = S_SHARE_FILL;
				end
			end
			S_SHARE_FILL: begin
				cmd.op = OP_SHARE_FILL;
				if (stat.c_last) begin
					state_d = S_OUT_INIT;
				end
			end
			S_OUT_INIT: begin
				cmd.op  = OP_CLR_C;
				state_d = S_OUT_LOAD;
			end
			S_OUT_LOAD: begin
				cmd.op  = OP_OUT_LOAD;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.c_last) begin
						cmd.op  = OP_FINISH;
						state_d = S_IDLE;
					end else begin
						cmd.op  = OP_OUT_NEXT;
						state_d = S_OUT_LOAD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/fuzzy_membership_update_top.sv
// Fuzzy c-means membership update for one pixel.
// Input channel (in_valid/in_ready): one signed Q16.16 distance per transaction,
// last marks the final cluster of the pixel. Distances beyond MAX_CLUSTERS are
// dropped, but a last flag on them still closes the pixel.
// Output channel (out_valid/out_ready): one transaction per stored cluster with
// the new and previous Q1.16 membership, the winning cluster and last_result.
// Configuration: cfg_wr_en writes fuzzy_exponent (Q4.12).
// Operation: after the last distance, with all stored distances positive, the log2
// of each distance is taken (normalise, then 16 square steps); then for each
// cluster a row of exp2 terms is summed, each exp2 built from 16 multiply steps,
// and a 41-step restoring divide gives its membership. A pixel with a zero or
// negative distance instead takes a single divide whose quotient goes to each
// such cluster. Each result is then loaded into the output register and offered
// until taken. One pixel is worked at a time and input is held off meanwhile,
// so the next distance is taken the cycle after the last result.
// Reset clears the counters, loads fuzzy_exponent with 4096 and sets all
// stored memberships to zero. When the receiver stalls the result is held
// in the output register until taken.
module fuzzy_membership_update_top #(
	parameter int MAX_CLUSTERS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fmu_pkg::EXP_W-1:0]           cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fmu_pkg::DIST_W-1:0]   distance,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fmu_pkg::IDX_W-1:0]           cluster_index,
	output logic [fmu_pkg::MEMB_W-1:0]          membership,
	output logic [fmu_pkg::MEMB_W-1:0]          previous_membership,
	output logic [fmu_pkg::IDX_W-1:0]           best_cluster,
	output logic                                last_result
);
	import fmu_pkg::*;

	cmd_t    cmd;
	status_t stat;

	// Sequencer
	fmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and stores
	fmu_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.distance            (distance),
		.cluster_index       (cluster_index),
		.membership          (membership),
		.previous_membership (previous_membership),
		.best_cluster        (best_cluster),
		.last_result         (last_result)
	);

endmodule

FILE: sim/tb_fuzzy_membership_update_top.sv
`timescale 1ns / 100ps

module tb_fuzzy_membership_update_top;
	import fmu_pkg::*;

	localparam int N_CLUSTERS = 8;
	localparam int T_CLAMP    = 32 * 65536;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYC = 100;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [MEMB_W-1:0] memb;
		logic [MEMB_W-1:0] prev;
		logic [IDX_W-1:0]  best;
		logic              fin;
	} memb_result_t;

	typedef struct {
		logic [DIST_W-1:0] dval;
		logic              fin;
		logic              known;
		logic [MEMB_W-1:0] first_memb;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [EXP_W-1:0]         cfg_wr_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DIST_W-1:0] distance;
	logic                     last;
	logic                     out_valid;
	logic                     out_ready;
	logic [IDX_W-1:0]         cluster_index;
	logic [MEMB_W-1:0]        membership;
	logic [MEMB_W-1:0]        previous_membership;
	logic [IDX_W-1:0]         best_cluster;
	logic                     last_result;

	// Predictor state
	longint            pix_dist [N_CLUSTERS];
	logic [MEMB_W-1:0] pix_memb [N_CLUSTERS];
	int                pix_count;
	int                pix_nonpos;
	logic [EXP_W-1:0]  fuzz_exp;
	logic [63:0]       sqrt2_chain [17];

	memb_result_t expected_memb [$];
	int           first_slot;
	int           n_errors;
	int           idle_cycles;
	int           burst_left;
	bit           ready_steady;

	fuzzy_membership_update_top #(.MAX_CLUSTERS(N_CLUSTERS)) u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.distance           (distance),
		.last               (last),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.cluster_index      (cluster_index),
		.membership         (membership),
		.previous_membership(previous_membership),
		.best_cluster       (best_cluster),
		.last_result        (last_result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Integer square root by bitwise search
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic longint log2_q16(input logic [63:0] v);
		int          p;
		logic [63:0] x;
		logic [15:0] fr;
		p  = 0;
		fr = '0;
		while (p < 62 && (v >> (p + 1)) != 0)
			p++;
		x = v << (31 - p);
		for (int k = 0; k < 16; k++) begin
			x  = (x * x) >> 31;
			fr = {fr[14:0], 1'b0};
			if (x >= 64'h1_0000_0000) begin
				fr[0] = 1'b1;
				x     = x >> 1;
			end
		end
		return longint'(p) * 65536 + longint'(fr);
	endfunction

	// Scale the log difference by the exponent, floor, then clamp
	function automatic longint scale_by_exp(input longint diff);
		longint prod;
		longint t;
		prod = diff * longint'(fuzz_exp);
		t    = prod >>> 12;
		if (t < -T_CLAMP)
			t = -T_CLAMP;
		if (t > T_CLAMP - 1)
			t = T_CLAMP - 1;
		return t;
	endfunction

	function automatic logic [63:0] pow2_q24(input longint t);
		logic [63:0] u;
		int          n;
		logic [15:0] f;
		logic [63:0] mant;
		u    = t + T_CLAMP;
		n    = int'(u >> 16) - 32;
		f    = u[15:0];
		mant = 64'd1 << 30;
		for (int j = 15; j >= 0; j--)
			if (f[j])
				mant = (mant * sqrt2_chain[16 - j]) >> 30;
		if (n >= 6)
			return mant << (n - 6);
		return mant >> (6 - n);
	endfunction

	// Record one distance and, once the pixel's last distance arrives, work out its memberships
	task automatic predict_pixel(input logic signed [DIST_W-1:0] d, input logic fin);
		logic [MEMB_W-1:0] fresh [N_CLUSTERS];
		longint            lg [N_CLUSTERS];
		logic [63:0]       sum;
		logic [63:0]       one40;
		int                winner;
		memb_result_t      r;
		one40 = 64'd1 << 40;
		if (pix_count < N_CLUSTERS) begin
			pix_dist[pix_count] = longint'(d);
			pix_count++;
			if (d <= 0)
				pix_nonpos++;
		end
		if (!fin)
			return;
		if (pix_nonpos == 0) begin
			for (int c = 0; c < pix_count; c++)
				lg[c] = log2_q16(pix_dist[c]);
			for (int c = 0; c < pix_count; c++) begin
				sum = '0;
				for (int i = 0; i < pix_count; i++)
					sum += pow2_q24(scale_by_exp(lg[c] - lg[i]));
				fresh[c] = MEMB_W'(one40 / sum);
			end
		end else begin
			for (int c = 0; c < pix_count; c++)
				fresh[c] = (pix_dist[c] <= 0) ? MEMB_W'(65536 / pix_nonpos) : '0;
		end
		winner = 0;
		for (int c = 1; c < pix_count; c++)
			if (fresh[c] > fresh[winner])
				winner = c;
		// Note where this pixel's first transaction sits in the queue
		first_slot = expected_memb.size();
		for (int c = 0; c < pix_count; c++) begin
			r.idx  = IDX_W'(c);
			r.memb = fresh[c];
			r.prev = pix_memb[c];
			r.best = IDX_W'(winner);
			r.fin  = (c + 1 == pix_count);
			expected_memb.push_back(r);
			pix_memb[c] = fresh[c];
		end
		pix_count  = 0;
		pix_nonpos = 0;
	endtask

	task automatic note_error(input string what);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch: %s", what);
	endtask

	// Offer one distance, honouring the burst/gap pattern, and predict on accept
	task automatic send_distance(input logic signed [DIST_W-1:0] d, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		distance <= d;
		last     <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		predict_pixel(d, fin);
	endtask

	// Hold input off until every pending transaction has drained
	task automatic drain_results();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (expected_memb.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_exponent(input logic [EXP_W-1:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fuzz_exp  = v;
		@(posedge clk);
	endtask

	function automatic logic [DIST_W-1:0] pick_distance();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return DIST_W'($urandom_range(1, 1 << 20));
		if (sel < 72)
			return DIST_W'($urandom);
		if (sel < 76)
			return 32'h7FFF_FFFF;
		if (sel < 80)
			return 32'd1;
		if (sel < 84)
			return 32'd0;
		if (sel < 88)
			return 32'h8000_0000;
		if (sel < 93)
			return -DIST_W'($urandom_range(1, 1 << 20));
		return DIST_W'($urandom_range(1, 1 << 20)) | 32'h8000_0000;
	endfunction

	// One pixel; now and then an over-long one that spills past the store
	task automatic send_pixel(output int n_sent);
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
		for (int k = 0; k < n; k++)
			send_distance(pick_distance(), k == n - 1);
		n_sent = n;
	endtask

	// Receiver: stretches of steady ready, otherwise random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				ready_steady = !ready_steady;
			out_ready <= ready_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// Compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		memb_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_memb.size() == 0) begin
				note_error($sformatf("unexpected result idx=%0d memb=%0d",
					cluster_index, membership));
			end else begin
				e = expected_memb.pop_front();
				if (cluster_index !== e.idx)
					note_error($sformatf("cluster_index exp %0d got %0d",
						e.idx, cluster_index));
				if (membership !== e.memb)
					note_error($sformatf("membership[%0d] exp %0d got %0d",
						e.idx, e.memb, membership));
				if (previous_membership !== e.prev)
					note_error($sformatf("previous_membership[%0d] exp %0d got %0d",
						e.idx, e.prev, previous_membership));
				if (best_cluster !== e.best)
					note_error($sformatf("best_cluster exp %0d got %0d",
						e.best, best_cluster));
				if (last_result !== e.fin)
					note_error($sformatf("last_result[%0d] exp %0d got %0d",
						e.idx, e.fin, last_result));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		plan_row_t   plan [22];
		logic [EXP_W-1:0] exp_list [6];
		int          sent;
		int          n_sent;
		plan = '{
			'{32'h0000_0000, 1'b1, 1'b1, 17'd65536},
			'{32'h8000_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0000_0005, 1'b1, 1'b1, 17'd65536},
			'{32'h0000_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0000_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0000_0000, 1'b1, 1'b1, 17'd21845},
			'{32'h7FFF_FFFF, 1'b0, 1'b0, 17'd0},
			'{32'h0000_0001, 1'b1, 1'b0, 17'd0},
			'{32'd1, 1'b0, 1'b0, 17'd0},
			'{32'd2, 1'b0, 1'b0, 17'd0},
			'{32'd3, 1'b0, 1'b0, 17'd0},
			'{32'd4, 1'b0, 1'b0, 17'd0},
			'{32'd5, 1'b0, 1'b0, 17'd0},
			'{32'd6, 1'b0, 1'b0, 17'd0},
			'{32'd7, 1'b0, 1'b0, 17'd0},
			'{32'd8, 1'b0, 1'b0, 17'd0},
			'{32'd9, 1'b1, 1'b0, 17'd0},
			'{32'h0001_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0001_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0001_0000, 1'b0, 1'b0, 17'd0},
			'{32'h0001_0000, 1'b1, 1'b1, 17'd16384},
			'{32'h0001_0000, 1'b1, 1'b1, 17'd65536}
		};
		exp_list = '{16'd0, 16'd1, 16'd65535, 16'd8192, 16'd4096, 16'd0};
		exp_list[5] = EXP_W'($urandom_range(1, 65535));

		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		distance     = '0;
		last         = 1'b0;
		n_errors     = 0;
		burst_left   = 0;
		first_slot   = 0;
		pix_count    = 0;
		pix_nonpos   = 0;
		fuzz_exp     = EXP_RST;
		for (int c = 0; c < N_CLUSTERS; c++) begin
			pix_dist[c] = 0;
			pix_memb[c] = '0;
		end
		sqrt2_chain[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++)
			sqrt2_chain[k] = root_floor(sqrt2_chain[k - 1] << 30);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset exponent
		foreach (plan[r]) begin
			send_distance(plan[r].dval, plan[r].fin);
			if (plan[r].known && expected_memb[first_slot].memb !== plan[r].first_memb)
				note_error($sformatf("row %0d: predicted %0d, table says %0d",
					r, expected_memb[first_slot].memb, plan[r].first_memb));
		end

		// Random pixels across a range of exponent settings
		foreach (exp_list[p]) begin
			set_exponent(exp_list[p]);
			sent = 0;
			while (sent < 40) begin
				send_pixel(n_sent);
				sent += n_sent;
			end
		end

		drain_results();
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: fuzzy_membership_update_top.f
hw/rtl/fmu_pkg.sv
hw/rtl/fmu_datapath.sv
hw/rtl/fmu_ctrl.sv
hw/rtl/fuzzy_membership_update_top.sv
sim/tb_fuzzy_membership_update_top.sv
